[src/dcr_pkg.sv]
// Shared widths, types and the clip helper for the distance constraint pipeline.
// Depends on nothing; imported by distance_constraint_relax_top.
`default_nettype none

package dcr_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int FRAC_BITS   = 8;
	localparam int LEN_WIDTH   = 16;

	// widths that follow from the coordinate, length and fraction widths
	localparam int DXW    = COORD_WIDTH + 1;
	localparam int ROOT_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int LW     = LEN_WIDTH + FRAC_BITS;
	localparam int DMW    = (ROOT_W > LW) ? ROOT_W : LW;
	localparam int DIFF_W = DMW + 1;
	localparam int PROD_W = COORD_WIDTH + DMW;
	localparam int SUM_W  = PROD_W + 2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x1;
		coord_t y1;
		coord_t x2;
		coord_t y2;
	} pos_t;

	typedef struct packed {
		pos_t                   pos;
		logic [LEN_WIDTH-1:0]   len;
		logic [COORD_WIDTH-1:0] adx;
		logic [COORD_WIDTH-1:0] ady;
		logic                   ndx;
		logic                   ndy;
	} geo_t;

	typedef struct packed {
		coord_t value;
		logic   sat;
	} clip_t;

	function automatic clip_t clip_f(input logic signed [SUM_W-1:0] v);
		clip_t res;
		logic  fits;
		fits = (&v[SUM_W-1:COORD_WIDTH-1]) | ~(|v[SUM_W-1:COORD_WIDTH-1]);
		res.sat = ~fits;
		if (fits) begin
			res.value = v[COORD_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			res.value = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			res.value = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[src/distance_constraint_relax_top.sv]
// Pipelined stick relaxation: difference, squares, bit-per-stage root, products,
// bit-per-stage dividers, correction and clip. Uses dcr_pkg.
// Depth: a 25-stage root and a 49-stage divide at Q16.8.
// Throughput: one transaction per cycle; every stage advances together, so
// a stalled result holds the whole pipeline and nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the output valid; data regs are not reset.
`default_nettype none

module distance_constraint_relax_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic signed [dcr_pkg::COORD_WIDTH-1:0] first_x,
	input  logic signed [dcr_pkg::COORD_WIDTH-1:0] first_y,
	input  logic signed [dcr_pkg::COORD_WIDTH-1:0] second_x,
	input  logic signed [dcr_pkg::COORD_WIDTH-1:0] second_y,
	input  logic        [dcr_pkg::LEN_WIDTH-1:0]   rest_length,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [dcr_pkg::COORD_WIDTH-1:0] new_first_x,
	output logic signed [dcr_pkg::COORD_WIDTH-1:0] new_first_y,
	output logic signed [dcr_pkg::COORD_WIDTH-1:0] new_second_x,
	output logic signed [dcr_pkg::COORD_WIDTH-1:0] new_second_y,
	output logic                                 saturated
);
	import dcr_pkg::*;

	logic en;
	assign en = !result_valid || result_ready;
	assign item_ready = en;

	// stage 1: capture and take differences
	logic                  v_s1;
	pos_t                  pos_s1;
	logic [LEN_WIDTH-1:0]  len_s1;
	logic signed [DXW-1:0] dx_s1, dy_s1;

	// stage 2: magnitudes, stage 3: squares
	logic                     v_s2, v_s3;
	geo_t                     g_s2, g_s3;
	logic [2*COORD_WIDTH-1:0] sqx_s3, sqy_s3;

	// stage 4: root, one result bit per stage
	logic              sq_v_s    [0:ROOT_W];
	geo_t              sq_g_s    [0:ROOT_W];
	logic [SQ_W-1:0]   sq_rad_s  [0:ROOT_W];
	logic [ROOT_W:0]   sq_rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [0:ROOT_W];

	// stage 5: coincident fix and length difference, stage 6: magnitude of difference
	logic              v_s5, v_s6;
	geo_t              g_s5, g_s6;
	logic [ROOT_W-1:0] r_s5, r_s6;
	logic [DIFF_W-1:0] diff_s5;
	logic [DMW-1:0]    dmag_s6;
	logic              nx_s6, ny_s6;

	// stage 7: products and dividers, one quotient bit per stage
	logic              dv_v_s    [0:PROD_W];
	pos_t              dv_pos_s  [0:PROD_W];
	logic [ROOT_W-1:0] dv_r_s    [0:PROD_W];
	logic              dv_nx_s   [0:PROD_W];
	logic              dv_ny_s   [0:PROD_W];
	logic [PROD_W-1:0] dv_dx_s   [0:PROD_W];
	logic [PROD_W-1:0] dv_dy_s   [0:PROD_W];
	logic [ROOT_W-1:0] dv_remx_s [0:PROD_W];
	logic [ROOT_W-1:0] dv_remy_s [0:PROD_W];
	logic [PROD_W-1:0] dv_qx_s   [0:PROD_W];
	logic [PROD_W-1:0] dv_qy_s   [0:PROD_W];

	// stage 8: corrected sums before clipping
	logic                    v_s8;
	logic signed [SUM_W-1:0] fx1_s8, fy1_s8, fx2_s8, fy2_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			sq_v_s[0] <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			dv_v_s[0] <= 1'b0;
			v_s8 <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			sq_v_s[0] <= v_s3;
			v_s5 <= sq_v_s[ROOT_W];
			v_s6 <= v_s5;
			dv_v_s[0] <= v_s6;
			v_s8 <= dv_v_s[PROD_W];
			result_valid <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= '{first_x, first_y, second_x, second_y};
			len_s1 <= rest_length;
			dx_s1  <= DXW'(second_x) - DXW'(first_x);
			dy_s1  <= DXW'(second_y) - DXW'(first_y);

			g_s2.pos <= pos_s1;
			g_s2.len <= len_s1;
			g_s2.adx <= COORD_WIDTH'(dx_s1[DXW-1] ? -dx_s1 : dx_s1);
			g_s2.ady <= COORD_WIDTH'(dy_s1[DXW-1] ? -dy_s1 : dy_s1);
			g_s2.ndx <= dx_s1[DXW-1];
			g_s2.ndy <= dy_s1[DXW-1];

			g_s3   <= g_s2;
			sqx_s3 <= g_s2.adx * g_s2.adx;
			sqy_s3 <= g_s2.ady * g_s2.ady;

			sq_g_s[0]    <= g_s3;
			sq_rad_s[0]  <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
			logic [ROOT_W+2:0] t, trial, dlt;
			assign t     = {sq_rem_s[gi], sq_rad_s[gi][SQ_W-1 -: 2]};
			assign trial = {1'b0, sq_root_s[gi], 2'b01};
			assign dlt   = t - trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v_s[gi+1] <= 1'b0;
				end else if (en) begin
					sq_v_s[gi+1] <= sq_v_s[gi];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_g_s[gi+1]   <= sq_g_s[gi];
					sq_rad_s[gi+1] <= sq_rad_s[gi] << 2;
					if (t >= trial) begin
						sq_rem_s[gi+1]  <= dlt[ROOT_W:0];
						sq_root_s[gi+1] <= {sq_root_s[gi][ROOT_W-2:0], 1'b1};
					end else begin
						sq_rem_s[gi+1]  <= t[ROOT_W:0];
						sq_root_s[gi+1] <= {sq_root_s[gi][ROOT_W-2:0], 1'b0};
					end
				end
			end
		end
	endgenerate

	// zero distance counts as one pixel
	logic [ROOT_W-1:0] rfix;
	logic [DIFF_W-1:0] lshift;
	always_comb begin
		rfix   = (sq_root_s[ROOT_W] == '0) ? ROOT_W'(1 << FRAC_BITS) : sq_root_s[ROOT_W];
		lshift = DIFF_W'(sq_g_s[ROOT_W].len) << FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s5    <= sq_g_s[ROOT_W];
			r_s5    <= rfix;
			diff_s5 <= DIFF_W'(rfix) - lshift;

			g_s6    <= g_s5;
			r_s6    <= r_s5;
			dmag_s6 <= DMW'(diff_s5[DIFF_W-1] ? -diff_s5 : diff_s5);
			nx_s6   <= g_s5.ndx ^ diff_s5[DIFF_W-1];
			ny_s6   <= g_s5.ndy ^ diff_s5[DIFF_W-1];

			dv_pos_s[0]  <= g_s6.pos;
			dv_r_s[0]    <= r_s6;
			dv_nx_s[0]   <= nx_s6;
			dv_ny_s[0]   <= ny_s6;
			dv_dx_s[0]   <= g_s6.adx * dmag_s6;
			dv_dy_s[0]   <= g_s6.ady * dmag_s6;
			dv_remx_s[0] <= '0;
			dv_remy_s[0] <= '0;
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
		end
	end

	generate
		for (gi = 0; gi < PROD_W; gi++) begin : g_div
			logic [ROOT_W:0] tx, ty, dvs;
			logic            gex, gey;
			assign tx  = {dv_remx_s[gi], dv_dx_s[gi][PROD_W-1]};
			assign ty  = {dv_remy_s[gi], dv_dy_s[gi][PROD_W-1]};
			assign dvs = {1'b0, dv_r_s[gi]};
			assign gex = tx >= dvs;
			assign gey = ty >= dvs;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v_s[gi+1] <= 1'b0;
				end else if (en) begin
					dv_v_s[gi+1] <= dv_v_s[gi];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_pos_s[gi+1]  <= dv_pos_s[gi];
					dv_r_s[gi+1]    <= dv_r_s[gi];
					dv_nx_s[gi+1]   <= dv_nx_s[gi];
					dv_ny_s[gi+1]   <= dv_ny_s[gi];
					dv_dx_s[gi+1]   <= dv_dx_s[gi] << 1;
					dv_dy_s[gi+1]   <= dv_dy_s[gi] << 1;
					dv_remx_s[gi+1] <= gex ? ROOT_W'(tx - dvs) : tx[ROOT_W-1:0];
					dv_remy_s[gi+1] <= gey ? ROOT_W'(ty - dvs) : ty[ROOT_W-1:0];
					dv_qx_s[gi+1]   <= {dv_qx_s[gi][PROD_W-2:0], gex};
					dv_qy_s[gi+1]   <= {dv_qy_s[gi][PROD_W-2:0], gey};
				end
			end
		end
	endgenerate

	// halve the correction, apply its sign, add to first and take from second
	logic signed [SUM_W-1:0] hx, hy;
	always_comb begin
		hx = $signed(SUM_W'(dv_qx_s[PROD_W] >> 1));
		hy = $signed(SUM_W'(dv_qy_s[PROD_W] >> 1));
		if (dv_nx_s[PROD_W]) begin
			hx = -hx;
		end
		if (dv_ny_s[PROD_W]) begin
			hy = -hy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx1_s8 <= SUM_W'(dv_pos_s[PROD_W].x1) + hx;
			fy1_s8 <= SUM_W'(dv_pos_s[PROD_W].y1) + hy;
			fx2_s8 <= SUM_W'(dv_pos_s[PROD_W].x2) - hx;
			fy2_s8 <= SUM_W'(dv_pos_s[PROD_W].y2) - hy;
		end
	end

	clip_t cx1, cy1, cx2, cy2;
	always_comb begin
		cx1 = clip_f(fx1_s8);
		cy1 = clip_f(fy1_s8);
		cx2 = clip_f(fx2_s8);
		cy2 = clip_f(fy2_s8);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_first_x  <= cx1.value;
			new_first_y  <= cy1.value;
			new_second_x <= cx2.value;
			new_second_y <= cy2.value;
			saturated    <= cx1.sat | cy1.sat | cx2.sat | cy2.sat;
		end
	end

`ifndef SYNTHESIS
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> r_s5 != '0)
		else $error("divisor is zero after coincident fix");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_s[PROD_W] |-> (dv_remx_s[PROD_W] < dv_r_s[PROD_W])
			&& (dv_remy_s[PROD_W] < dv_r_s[PROD_W]))
		else $error("divider remainder not below divisor");

	a_drain_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && en |=> result_valid)
		else $error("finished transaction did not reach the output");
`endif

endmodule

`default_nettype wire
